>>> design/bce_pkg.sv
// Shared types, constants and tables of the Bezier curve evaluator.
// No dependencies; imported by bce_rdiv, bce_unit and bezier_curve_evaluator.
`default_nettype none
package bce_pkg;

  localparam int MAX_ORDER = 7;
  localparam int MAX_STEPS = 32;

  localparam int ORD_W  = 3;   // curve_order register
  localparam int STEP_W = 6;   // step count registers
  localparam int IDX_W  = 5;   // sample index
  localparam int CRD_W  = 16;  // coordinate and tangent component
  localparam int PT_W   = 2 * CRD_W;
  localparam int ACC_W  = 56;  // Horner accumulator
  localparam int DEN_W  = 36;  // step count raised to the order
  localparam int CFG_W  = 6;
  localparam int CIX_W  = 2;

  localparam logic [CIX_W-1:0] CFG_ORDER  = 2'd0;
  localparam logic [CIX_W-1:0] CFG_CSTEPS = 2'd1;
  localparam logic [CIX_W-1:0] CFG_TSTEPS = 2'd2;

  localparam logic KIND_POINT   = 1'b0;
  localparam logic KIND_TANGENT = 1'b1;

  // Pascal triangle, row n holds C(n,k)
  localparam int BINOM [8][8] = '{
    '{1, 0,  0,  0,  0,  0, 0, 0},
    '{1, 1,  0,  0,  0,  0, 0, 0},
    '{1, 2,  1,  0,  0,  0, 0, 0},
    '{1, 3,  3,  1,  0,  0, 0, 0},
    '{1, 4,  6,  4,  1,  0, 0, 0},
    '{1, 5, 10, 10,  5,  1, 0, 0},
    '{1, 6, 15, 20, 15,  6, 1, 0},
    '{1, 7, 21, 35, 35, 21, 7, 1}
  };

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DEN,
    ST_SINIT,
    ST_MUL1,
    ST_MUL2,
    ST_ADD,
    ST_START,
    ST_WAIT,
    ST_EMIT
  } top_state_t;

  typedef enum logic [2:0] {
    U_IDLE,
    U_SHIFT,
    U_SQ,
    U_SQR,
    U_TEST
  } unit_state_t;

endpackage
`default_nettype wire

>>> design/bce_rdiv.sv
// Rounding divider: signed numerator over unsigned denominator, ties away from zero.
// Restoring, one quotient bit per cycle. Depends on bce_pkg.
`default_nettype none
module bce_rdiv import bce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] num,
  input  logic [DEN_W-1:0]        den,
  output logic                    done,
  output logic signed [CRD_W-1:0] quo
);

  localparam int REM_W = ACC_W + 1;
  localparam int DSH_W = DEN_W + CRD_W - 1;
  localparam int CNT_W = $clog2(CRD_W);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [REM_W-1:0] rem_r;
  logic [DSH_W-1:0] dsh_r;
  logic [CRD_W-1:0] q_r;
  logic             neg_r;

  logic [ACC_W-1:0] num_mag;
  logic [REM_W-1:0] rem_init;
  logic [REM_W-1:0] dsh_ext;
  logic             fits;

  assign num_mag  = num[ACC_W-1] ? $unsigned(-num) : $unsigned(num);
  assign rem_init = {1'b0, num_mag} + REM_W'(den >> 1);
  assign dsh_ext  = REM_W'(dsh_r);
  assign fits     = rem_r >= dsh_ext;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(CRD_W - 1);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= rem_init;
      dsh_r <= {den, {(CRD_W-1){1'b0}}};
      q_r   <= '0;
      neg_r <= num[ACC_W-1];
    end else if (busy_r) begin
      if (fits) begin
        rem_r        <= rem_r - dsh_ext;
        q_r[cnt_r]   <= 1'b1;
      end
      dsh_r <= dsh_r >> 1;
    end
  end

  assign done = done_r;
  assign quo  = $signed(neg_r ? (~q_r + 1'b1) : q_r);

endmodule
`default_nettype wire

>>> design/bce_unit.sv
// Unit vector in Q1.14 from a wide derivative vector: shift both magnitudes
// below 2^16, then find each component bit by bit. Depends on bce_pkg.
`default_nettype none
module bce_unit import bce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [ACC_W-1:0] nx,
  input  logic signed [ACC_W-1:0] ny,
  output logic                    done,
  output logic signed [CRD_W-1:0] ux,
  output logic signed [CRD_W-1:0] uy
);

  localparam int Q_W   = CRD_W - 1;
  localparam int BIT_W = $clog2(Q_W);
  localparam int SQ_W  = 2 * CRD_W;
  localparam int LHS_W = 2 * SQ_W + 1;

  unit_state_t st_r, st_nxt;
  logic        done_r, done_nxt;

  logic [ACC_W-1:0] ax_r, ay_r;
  logic             negx_r, negy_r;
  logic [SQ_W:0]    s_r;
  logic [SQ_W-1:0]  asq_r, bsq_r;
  logic [SQ_W-1:0]  dx2_r, dy2_r;
  logic [Q_W-1:0]   qx_r, qy_r;
  logic [BIT_W-1:0] bit_r;

  logic             is_zero;
  logic             big;
  logic [Q_W-1:0]   cand_x, cand_y;
  logic [CRD_W-1:0] dx, dy;
  logic [SQ_W-1:0]  dx2_full, dy2_full, asq_full, bsq_full;
  logic [LHS_W-1:0] lhs_x, lhs_y, rhs_x, rhs_y;
  logic             ok_x, ok_y;

  assign is_zero  = (nx == '0) && (ny == '0);
  assign big      = |(ax_r[ACC_W-1:CRD_W] | ay_r[ACC_W-1:CRD_W]);
  assign cand_x   = qx_r | (Q_W'(1) << bit_r);
  assign cand_y   = qy_r | (Q_W'(1) << bit_r);
  assign dx       = {cand_x, 1'b0} - 1'b1;
  assign dy       = {cand_y, 1'b0} - 1'b1;
  assign dx2_full = dx * dx;
  assign dy2_full = dy * dy;
  assign asq_full = ax_r[CRD_W-1:0] * ax_r[CRD_W-1:0];
  assign bsq_full = ay_r[CRD_W-1:0] * ay_r[CRD_W-1:0];
  assign lhs_x    = dx2_r * s_r;
  assign lhs_y    = dy2_r * s_r;
  assign rhs_x    = LHS_W'({asq_r, 30'b0});
  assign rhs_y    = LHS_W'({bsq_r, 30'b0});
  assign ok_x     = lhs_x <= rhs_x;
  assign ok_y     = lhs_y <= rhs_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= U_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
  end

  always_comb begin
    st_nxt   = st_r;
    done_nxt = 1'b0;
    unique case (st_r)
      U_IDLE: begin
        if (start) begin
          if (is_zero) begin
            done_nxt = 1'b1;
          end else begin
            st_nxt = U_SHIFT;
          end
        end
      end
      U_SHIFT: begin
        if (!big) st_nxt = U_SQ;
      end
      U_SQ:  st_nxt = U_SQR;
      U_SQR: st_nxt = U_TEST;
      U_TEST: begin
        if (bit_r == '0) begin
          st_nxt   = U_IDLE;
          done_nxt = 1'b1;
        end else begin
          st_nxt = U_SQR;
        end
      end
      default: st_nxt = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (st_r)
      U_IDLE: begin
        if (start) begin
          ax_r   <= nx[ACC_W-1] ? $unsigned(-nx) : $unsigned(nx);
          ay_r   <= ny[ACC_W-1] ? $unsigned(-ny) : $unsigned(ny);
          negx_r <= nx[ACC_W-1];
          negy_r <= ny[ACC_W-1];
          qx_r   <= '0;
          qy_r   <= '0;
        end
      end
      U_SHIFT: begin
        if (big) begin
          ax_r <= ax_r >> 1;
          ay_r <= ay_r >> 1;
        end
      end
      U_SQ: begin
        asq_r <= asq_full;
        bsq_r <= bsq_full;
        s_r   <= {1'b0, asq_full} + {1'b0, bsq_full};
        bit_r <= BIT_W'(Q_W - 1);
      end
      U_SQR: begin
        dx2_r <= dx2_full;
        dy2_r <= dy2_full;
      end
      U_TEST: begin
        if (ok_x) qx_r <= cand_x;
        if (ok_y) qy_r <= cand_y;
        bit_r <= bit_r - 1'b1;
      end
      default: ;
    endcase
  end

  assign done = done_r;
  assign ux   = $signed(negx_r ? (~{1'b0, qx_r} + 1'b1) : {1'b0, qx_r});
  assign uy   = $signed(negy_r ? (~{1'b0, qy_r} + 1'b1) : {1'b0, qy_r});

endmodule
`default_nettype wire

>>> design/bezier_curve_evaluator.sv
// Bezier curve evaluator top level: point store, Horner sequencer, output register.
// Depends on bce_pkg, bce_rdiv and bce_unit.
//
// Control points arrive one request at a time; order+1 of them form a segment and
// the last point of a segment opens the next. A point that completes a segment
// starts a run of curve_steps curve points (Q11.4) followed by tangent_steps unit
// tangents (Q1.14); out_last marks the final tangent. The input stalls for the
// whole run. Points live in an 8-entry store with one write port and one registered
// read port; each sample is a Horner pass over the segment, through the states
// ST_MUL1, ST_MUL2 and ST_ADD for each control point. A curve point then takes
// the rounding divide; a tangent takes the normalizer, which shifts one bit a
// cycle and then tests 15 result bits, each in the states U_SQR and U_TEST.
// A run first forms the divisor, curve_steps raised to the order, in ST_DEN.
// A point that does not close a segment is accepted without a stall.
// Downstream stalls simply hold the sequencer.
`default_nettype none
module bezier_curve_evaluator import bce_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  logic signed [CRD_W-1:0] in_point_x,
  input  logic signed [CRD_W-1:0] in_point_y,
  input  logic                    in_new_curve,
  output logic                    out_valid,
  input  logic                    out_stall,
  output logic                    out_kind,
  output logic [IDX_W-1:0]        out_sample_index,
  output logic signed [CRD_W-1:0] out_x,
  output logic signed [CRD_W-1:0] out_y,
  output logic                    out_last,
  input  logic                    cfg_wr_en,
  input  logic [CIX_W-1:0]        cfg_index,
  input  logic [CFG_W-1:0]        cfg_data
);

  localparam int DEPTH  = MAX_ORDER + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int PH_W   = ADDR_W + 1;
  localparam int OP_W   = CRD_W + 1;
  localparam int PROD_W = DEN_W + OP_W + 1;
  localparam int BW_W   = 6;

  top_state_t state_r, state_nxt;

  // configuration
  logic [ORD_W-1:0]  order_r;
  logic [STEP_W-1:0] csteps_r, tsteps_r;
  logic [ORD_W-1:0]  n_eff, m_eff;
  logic [STEP_W-1:0] cs_eff, ts_eff, steps_eff;

  // point store
  logic [PT_W-1:0]   seg_mem [DEPTH];
  logic              mem_we, rd_en;
  logic [ADDR_W-1:0] mem_wa, rd_addr;
  logic [PT_W-1:0]   mem_wd, rdata_r;

  logic [PH_W-1:0]   ph_r;
  logic [ADDR_W-1:0] ph_eff, base_r, k_r;
  logic [PT_W-1:0]   lastpt_r, prev_r;
  logic              in_acc, start_seg, out_free, run_end;
  logic              kind_r, first_r;
  logic [IDX_W-1:0]  idx_r;

  // datapath
  logic [DEN_W-1:0]         den_r, pw_r, cw_r;
  logic signed [OP_W-1:0]   op_x_r, op_y_r, op_x_nxt, op_y_nxt;
  logic signed [ACC_W-1:0]  acc_x_r, acc_y_r, accb_x_r, accb_y_r;
  logic signed [PROD_W-1:0] prod_x_r, prod_y_r, prod_x_full, prod_y_full;
  logic signed [ACC_W+IDX_W:0] accb_x_full, accb_y_full;
  logic [DEN_W+STEP_W-1:0]  den_full, pw_full;
  logic [DEN_W+BW_W-1:0]    cw_full;
  logic [STEP_W-1:0]        a_val;
  logic [BW_W-1:0]          bw;
  logic signed [CRD_W-1:0]  cur_x, cur_y, prv_x, prv_y;
  logic                     last_flag;

  logic                    div_start, unit_start;
  logic                    div_done_x, div_done_y, unit_done;
  logic signed [CRD_W-1:0] div_qx, div_qy, unit_ux, unit_uy;

  logic                    out_valid_r, out_kind_r, out_last_r;
  logic [IDX_W-1:0]        out_idx_r;
  logic signed [CRD_W-1:0] out_x_r, out_y_r;

  // effective configuration
  assign n_eff     = (order_r == '0) ? ORD_W'(1) : order_r;
  assign m_eff     = kind_r ? (n_eff - 1'b1) : n_eff;
  assign cs_eff    = (csteps_r == '0) ? STEP_W'(1) :
                     (csteps_r > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : csteps_r;
  assign ts_eff    = (tsteps_r == '0) ? STEP_W'(1) :
                     (tsteps_r > STEP_W'(MAX_STEPS)) ? STEP_W'(MAX_STEPS) : tsteps_r;
  assign steps_eff = kind_r ? ts_eff : cs_eff;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign ph_eff    = (in_new_curve || (ph_r > PH_W'(MAX_ORDER))) ? '0 : ph_r[ADDR_W-1:0];
  assign start_seg = in_acc && (ph_eff >= n_eff);
  assign out_free  = !out_valid_r || !out_stall;
  assign last_flag = kind_r && ((STEP_W'(idx_r) + 1'b1) == ts_eff);
  assign run_end   = (state_r == ST_EMIT) && out_free && last_flag;

  // store access: new point on accept, chain point at the end of a run
  always_comb begin
    mem_we = 1'b0;
    mem_wa = ph_eff;
    mem_wd = {in_point_x, in_point_y};
    if (in_acc) begin
      mem_we = 1'b1;
    end else if (run_end) begin
      mem_we = 1'b1;
      mem_wa = '0;
      mem_wd = lastpt_r;
    end
  end

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = base_r + k_r - 1'b1;
    case (state_r)
      ST_SINIT: begin
        rd_en   = 1'b1;
        rd_addr = base_r + n_eff;
      end
      ST_MUL1: rd_en = first_r;
      ST_ADD:  rd_en = (k_r != '0);
      default: rd_en = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) seg_mem[mem_wa] <= mem_wd;
    if (rd_en) rdata_r <= seg_mem[rd_addr];
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      order_r  <= ORD_W'(3);
      csteps_r <= STEP_W'(16);
      tsteps_r <= STEP_W'(8);
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_ORDER:  order_r  <= cfg_data[ORD_W-1:0];
        CFG_CSTEPS: csteps_r <= cfg_data;
        CFG_TSTEPS: tsteps_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start_seg) state_nxt = ST_DEN;
      ST_DEN:   if (k_r == ADDR_W'(1)) state_nxt = ST_SINIT;
      ST_SINIT: state_nxt = ST_MUL1;
      ST_MUL1:  if (!first_r) state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_ADD;
      ST_ADD:   state_nxt = (k_r == '0) ? ST_START : ST_MUL1;
      ST_START: state_nxt = ST_WAIT;
      ST_WAIT:  if (kind_r ? unit_done : div_done_x) state_nxt = ST_EMIT;
      ST_EMIT:  if (out_free) state_nxt = last_flag ? ST_IDLE : ST_SINIT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  assign div_start  = (state_r == ST_START) && (kind_r == KIND_POINT);
  assign unit_start = (state_r == ST_START) && (kind_r == KIND_TANGENT);

  // control registers of the run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r    <= '0;
      kind_r  <= KIND_POINT;
      first_r <= 1'b0;
      idx_r   <= '0;
      k_r     <= '0;
      base_r  <= '0;
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (in_acc) ph_r <= PH_W'(ph_eff) + 1'b1;
          if (start_seg) begin
            base_r <= ph_eff - n_eff;
            k_r    <= n_eff;
            kind_r <= KIND_POINT;
            idx_r  <= '0;
          end
        end
        ST_DEN:   k_r <= k_r - 1'b1;
        ST_SINIT: begin
          k_r     <= n_eff;
          first_r <= kind_r;
        end
        ST_MUL1: begin
          // tangent pass: the top point only primes the difference
          if (first_r) begin
            first_r <= 1'b0;
            k_r     <= k_r - 1'b1;
          end
        end
        ST_ADD: if (k_r != '0) k_r <= k_r - 1'b1;
        ST_EMIT: begin
          if (out_free) begin
            if (last_flag) begin
              ph_r <= PH_W'(1);
            end else if ((STEP_W'(idx_r) + 1'b1) == steps_eff) begin
              kind_r <= KIND_TANGENT;
              idx_r  <= '0;
            end else begin
              idx_r <= idx_r + 1'b1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // Horner datapath: acc = acc * i + C(m,k) * (S-i)^(m-k) * P_k, k from m down to 0
  assign cur_x    = $signed(rdata_r[PT_W-1:CRD_W]);
  assign cur_y    = $signed(rdata_r[CRD_W-1:0]);
  assign prv_x    = $signed(prev_r[PT_W-1:CRD_W]);
  assign prv_y    = $signed(prev_r[CRD_W-1:0]);
  assign op_x_nxt = kind_r ? (OP_W'(prv_x) - OP_W'(cur_x)) : OP_W'(cur_x);
  assign op_y_nxt = kind_r ? (OP_W'(prv_y) - OP_W'(cur_y)) : OP_W'(cur_y);

  assign a_val       = steps_eff - STEP_W'(idx_r);
  assign bw          = BW_W'(BINOM[m_eff][k_r]);
  assign den_full    = den_r * cs_eff;
  assign pw_full     = pw_r * a_val;
  assign cw_full     = bw * pw_r;
  assign accb_x_full = acc_x_r * $signed({1'b0, idx_r});
  assign accb_y_full = acc_y_r * $signed({1'b0, idx_r});
  assign prod_x_full = $signed({1'b0, cw_r}) * op_x_r;
  assign prod_y_full = $signed({1'b0, cw_r}) * op_y_r;

  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_acc) lastpt_r <= {in_point_x, in_point_y};
        den_r <= DEN_W'(1);
      end
      ST_DEN:   den_r <= den_full[DEN_W-1:0];
      ST_SINIT: begin
        acc_x_r <= '0;
        acc_y_r <= '0;
        pw_r    <= DEN_W'(1);
      end
      ST_MUL1: begin
        prev_r <= rdata_r;
        if (!first_r) begin
          op_x_r   <= op_x_nxt;
          op_y_r   <= op_y_nxt;
          cw_r     <= cw_full[DEN_W-1:0];
          pw_r     <= pw_full[DEN_W-1:0];
          accb_x_r <= accb_x_full[ACC_W-1:0];
          accb_y_r <= accb_y_full[ACC_W-1:0];
        end
      end
      ST_MUL2: begin
        prod_x_r <= prod_x_full;
        prod_y_r <= prod_y_full;
      end
      ST_ADD: begin
        acc_x_r <= accb_x_r + {{(ACC_W-PROD_W){prod_x_r[PROD_W-1]}}, prod_x_r};
        acc_y_r <= accb_y_r + {{(ACC_W-PROD_W){prod_y_r[PROD_W-1]}}, prod_y_r};
      end
      default: ;
    endcase
  end

  bce_rdiv u_div_x (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_x_r),
    .den   (den_r),
    .done  (div_done_x),
    .quo   (div_qx)
  );

  bce_rdiv u_div_y (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (acc_y_r),
    .den   (den_r),
    .done  (div_done_y),
    .quo   (div_qy)
  );

  bce_unit u_unit (
    .clk   (clk),
    .rst_n (rst_n),
    .start (unit_start),
    .nx    (acc_x_r),
    .ny    (acc_y_r),
    .done  (unit_done),
    .ux    (unit_ux),
    .uy    (unit_uy)
  );

  // output register: load when the slot is free, drop on accept
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_EMIT) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_EMIT) && out_free) begin
      out_kind_r <= kind_r;
      out_idx_r  <= idx_r;
      out_x_r    <= kind_r ? unit_ux : div_qx;
      out_y_r    <= kind_r ? unit_uy : div_qy;
      out_last_r <= last_flag;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_sample_index = out_idx_r;
  assign out_x            = out_x_r;
  assign out_y            = out_y_r;
  assign out_last         = out_last_r;

  // checks
  a_chain_one: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT) && (state_nxt == ST_IDLE) |=> (ph_r == PH_W'(1)))
    else $error("run ended without chaining its last point");

  a_read_held: assert property (@(posedge clk) disable iff (!rst_n)
    rd_en |-> (PH_W'(rd_addr) < ph_r))
    else $error("store read beyond held points");

  a_div_pair: assert property (@(posedge clk) disable iff (!rst_n)
    div_done_x |-> (div_done_y && (state_r == ST_WAIT)))
    else $error("dividers out of step");

  a_unit_wait: assert property (@(posedge clk) disable iff (!rst_n)
    unit_done |-> (state_r == ST_WAIT) && (kind_r == KIND_TANGENT))
    else $error("normalizer finished outside a tangent wait");

endmodule
`default_nettype wire

>>> sim/bezier_curve_evaluator_tb.sv
// Self-checking testbench for bezier_curve_evaluator: control point requests in,
// curve point and unit tangent results out, checked against an in-bench predictor.
// Depends on bce_pkg and the design files under design/.
`default_nettype none
module bezier_curve_evaluator_tb;
  import bce_pkg::*;

  typedef struct {
    bit                    kind;
    bit [IDX_W-1:0]        idx;
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    bit                    last;
  } sample_t;

  typedef struct {
    logic signed [CRD_W-1:0] px;
    logic signed [CRD_W-1:0] py;
    bit                    nc;
    bit                    typed;   // first curve point is known by eye
    logic signed [CRD_W-1:0] fx;
    logic signed [CRD_W-1:0] fy;
  } point_row_t;

  typedef struct {
    int ord;
    int cs;
    int ts;
    int count;
  } phase_t;

  logic                    clk = 1'b0;
  logic                    rst_n = 1'b0;
  logic                    in_valid = 1'b0;
  logic                    in_stall;
  logic signed [CRD_W-1:0] in_point_x = '0;
  logic signed [CRD_W-1:0] in_point_y = '0;
  logic                    in_new_curve = 1'b0;
  logic                    out_valid;
  logic                    out_stall = 1'b0;
  logic                    out_kind;
  logic [IDX_W-1:0]        out_sample_index;
  logic signed [CRD_W-1:0] out_x;
  logic signed [CRD_W-1:0] out_y;
  logic                    out_last;
  logic                    cfg_wr_en = 1'b0;
  logic [CIX_W-1:0]        cfg_index = '0;
  logic [CFG_W-1:0]        cfg_data = '0;

  bezier_curve_evaluator dut (.*);

  always #6 clk = ~clk;

  // predictor state
  logic signed [CRD_W-1:0] seg_x [8];
  logic signed [CRD_W-1:0] seg_y [8];
  int unsigned             held;
  bit [ORD_W-1:0]          order_reg;
  bit [STEP_W-1:0]         csteps_reg;
  bit [STEP_W-1:0]         tsteps_reg;

  sample_t pending_samples[$];
  int      errors = 0;
  int      points_sent = 0;
  int      samples_checked = 0;
  int      segments_seen = 0;
  bit      calm = 1'b0;
  bit      hold_req = 1'b0;

  function automatic longint ipow(longint b, int e);
    longint r;
    r = 1;
    repeat (e) r = r * b;
    return r;
  endfunction

  function automatic longint binom(int n, int k);
    longint r;
    r = 1;
    for (int i = 0; i < k; i++) r = r * (n - i) / (i + 1);
    return r;
  endfunction

  function automatic longint div_nearest(longint num, longint den);
    if (num >= 0) return (num + den / 2) / den;
    return -((-num + den / 2) / den);
  endfunction

  // largest q with (2q-1)^2 * s <= a^2 * 2^30, i.e. rounded 16384*a/|v|
  function automatic longint unsigned unit_mag(longint unsigned a, longint unsigned s);
    longint unsigned lo, hi, mid, d, rhs;
    lo = 0;
    hi = 16384;
    rhs = (a * a) << 30;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      d = 2 * mid - 1;
      if (d * d * s <= rhs) lo = mid;
      else hi = mid - 1;
    end
    return lo;
  endfunction

  function automatic void unit_tangent(longint nx, longint ny, output longint ux,
                                       output longint uy);
    longint unsigned ax, ay, m, s;
    int k;
    ax = nx < 0 ? -nx : nx;
    ay = ny < 0 ? -ny : ny;
    m = ax > ay ? ax : ay;
    k = 0;
    ux = 0;
    uy = 0;
    if (m == 0) return;
    while (k < 63 && (m >> k) >= 65536) k++;
    ax = ax >> k;
    ay = ay >> k;
    s = ax * ax + ay * ay;
    ux = unit_mag(ax, s);
    uy = unit_mag(ay, s);
    if (nx < 0) ux = -ux;
    if (ny < 0) uy = -uy;
  endfunction

  // append one expected result to the tail of the queue
  function automatic void expect_sample(sample_t r);
    pending_samples = {pending_samples, r};
  endfunction

  // store one control point; on a closed segment queue its curve points and tangents
  function automatic int predict_segment_run(logic signed [CRD_W-1:0] px,
                                             logic signed [CRD_W-1:0] py, bit nc);
    int n, cs, ts, base;
    longint sx, sy, den, w, ux, uy;
    sample_t r;
    n = order_reg == 0 ? 1 : order_reg;
    cs = csteps_reg == 0 ? 1 : (csteps_reg > MAX_STEPS ? MAX_STEPS : csteps_reg);
    ts = tsteps_reg == 0 ? 1 : (tsteps_reg > MAX_STEPS ? MAX_STEPS : tsteps_reg);
    if (nc) held = 0;
    if (held > MAX_ORDER) held = 0;
    seg_x[held] = px;
    seg_y[held] = py;
    held++;
    if (held < n + 1) return 0;
    base = held - (n + 1);
    den = ipow(cs, n);
    for (int i = 0; i < cs; i++) begin
      sx = 0;
      sy = 0;
      for (int j = 0; j <= n; j++) begin
        w = binom(n, j) * ipow(cs - i, n - j) * ipow(i, j);
        sx += w * seg_x[base + j];
        sy += w * seg_y[base + j];
      end
      r.kind = KIND_POINT;
      r.idx = IDX_W'(i);
      r.x = CRD_W'(div_nearest(sx, den));
      r.y = CRD_W'(div_nearest(sy, den));
      r.last = 1'b0;
      expect_sample(r);
    end
    for (int i = 0; i < ts; i++) begin
      sx = 0;
      sy = 0;
      for (int j = 0; j < n; j++) begin
        w = binom(n - 1, j) * ipow(ts - i, n - 1 - j) * ipow(i, j);
        sx += w * (longint'(seg_x[base + j + 1]) - seg_x[base + j]);
        sy += w * (longint'(seg_y[base + j + 1]) - seg_y[base + j]);
      end
      unit_tangent(sx, sy, ux, uy);
      r.kind = KIND_TANGENT;
      r.idx = IDX_W'(i);
      r.x = CRD_W'(ux);
      r.y = CRD_W'(uy);
      r.last = (i + 1 == ts);
      expect_sample(r);
    end
    seg_x[0] = seg_x[held - 1];
    seg_y[0] = seg_y[held - 1];
    held = 1;
    segments_seen++;
    return cs + ts;
  endfunction

  // result checker
  always @(posedge clk) begin
    sample_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_samples.size() == 0) begin
        $error("unexpected result kind=%0d idx=%0d x=%0d y=%0d", out_kind,
               out_sample_index, out_x, out_y);
        errors++;
      end else begin
        e = pending_samples.pop_front();
        samples_checked++;
        if (out_kind !== e.kind) begin
          $error("kind: expected %0d, got %0d", e.kind, out_kind);
          errors++;
        end
        if (out_sample_index !== e.idx) begin
          $error("sample_index: expected %0d, got %0d", e.idx, out_sample_index);
          errors++;
        end
        if (out_x !== e.x) begin
          $error("out_x: expected %0d, got %0d", e.x, out_x);
          errors++;
        end
        if (out_y !== e.y) begin
          $error("out_y: expected %0d, got %0d", e.y, out_y);
          errors++;
        end
        if (out_last !== e.last) begin
          $error("last: expected %0d, got %0d", e.last, out_last);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure
  initial begin
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 18)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  end

  initial begin
    #(12 * 4000000);
    $display("bezier_curve_evaluator verification failed");
    $finish;
  end

  task automatic write_reg(logic [CIX_W-1:0] idx, int val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_W'(val);
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_ORDER:  order_reg = ORD_W'(val);
      CFG_CSTEPS: csteps_reg = STEP_W'(val);
      CFG_TSTEPS: tsteps_reg = STEP_W'(val);
      default: ;
    endcase
  endtask

  // hold until every expected result is back, then let a trailing point settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_samples.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // offer one request until an edge accepts it; outside the calm phase, sometimes drop in_valid before returning
  task automatic send_point(point_row_t p);
    int before_cnt;
    in_valid <= 1'b1;
    in_point_x <= p.px;
    in_point_y <= p.py;
    in_new_curve <= p.nc;
    do @(posedge clk); while (in_stall);
    points_sent++;
    before_cnt = pending_samples.size();
    if (predict_segment_run(p.px, p.py, p.nc) > 0 && p.typed) begin
      pending_samples[before_cnt].x = p.fx;
      pending_samples[before_cnt].y = p.fy;
    end
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  function automatic logic signed [CRD_W-1:0] rand_coord();
    case ($urandom_range(0, 3))
      0: return CRD_W'($urandom_range(0, 128) - 64);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return CRD_W'($urandom_range(0, 65535));
    endcase
  endfunction

  point_row_t opening_rows[] = '{
    '{-32768, 32767, 1, 0, 0, 0},
    '{0, 0, 0, 0, 0, 0},
    '{1, -1, 0, 0, 0, 0},
    '{32767, -32768, 0, 1, -32768, 32767},
    // flat segment: all tangents collapse to zero
    '{80, -80, 1, 0, 0, 0},
    '{80, -80, 0, 0, 0, 0},
    '{80, -80, 0, 0, 0, 0},
    '{80, -80, 0, 1, 80, -80},
    // chained segment reuses the previous end point
    '{0, 0, 0, 0, 0, 0},
    '{16, 16, 0, 0, 0, 0},
    '{32, 32, 0, 1, 80, -80},
    // restart in the middle of a chain
    '{1, 2, 0, 0, 0, 0},
    '{3, 4, 1, 0, 0, 0},
    '{5, 6, 0, 0, 0, 0},
    '{7, 8, 0, 0, 0, 0},
    '{9, 10, 0, 1, 3, 4}
  };

  // order 0 and step counts 0 and 63 are clamped; 7 then 1 lowers order mid-chain
  phase_t phases[] = '{
    '{1, 1, 1, 24}, '{7, 32, 32, 22}, '{0, 0, 63, 20}, '{7, 2, 2, 6},
    '{1, 3, 2, 20}, '{2, 5, 3, 20}, '{4, 8, 6, 20}, '{3, 16, 8, 24},
    '{5, 4, 4, 20}, '{6, 3, 7, 20}, '{2, 32, 1, 20}, '{1, 6, 6, 20},
    '{-1, 0, 0, 12}, '{-1, 0, 0, 12}, '{-1, 0, 0, 12}, '{-1, 0, 0, 12},
    '{3, 4, 5, 24}
  };

  initial begin
    point_row_t p;
    phase_t ph;
    held = 0;
    order_reg = 3;
    csteps_reg = 16;
    tsteps_reg = 8;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (opening_rows[r]) send_point(opening_rows[r]);
    drain();

    foreach (phases[k]) begin
      ph = phases[k];
      if (ph.ord < 0) begin
        ph.ord = $urandom_range(1, 7);
        ph.cs = $urandom_range(1, 8);
        ph.ts = $urandom_range(1, 8);
      end
      calm = (k == phases.size() - 1);
      write_reg(CFG_ORDER, ph.ord);
      write_reg(CFG_CSTEPS, ph.cs);
      write_reg(CFG_TSTEPS, ph.ts);
      for (int i = 0; i < ph.count; i++) begin
        p.px = rand_coord();
        p.py = rand_coord();
        p.nc = (i > 0 && $urandom_range(0, 9) == 0);
        p.typed = 1'b0;
        p.fx = '0;
        p.fy = '0;
        if (k == 7 && i == 5) hold_req = 1'b1;
        if (k == 7 && i == 12) begin
          in_valid <= 1'b0;
          @(posedge clk);
          while (pending_samples.size() != 0) @(posedge clk);
        end
        send_point(p);
      end
      drain();
    end

    $display("covered %0d control points, %0d segments, %0d results compared",
             points_sent, segments_seen, samples_checked);
    $display("orders 0..7, step counts 0..63, restarts and a lowered order in mid-chain");
    if (errors == 0) begin
      $display("bezier_curve_evaluator verification clean");
    end else begin
      $display("bezier_curve_evaluator verification failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
